// ===== design/fpsc_pkg.sv =====
// ----------------------------------------------------------------------------
// fpsc_pkg - filtered PI speed controller shared definitions
// Configuration layout, sequencer states and shared-unit opcodes.
// ----------------------------------------------------------------------------
`default_nettype none

package fpsc_pkg;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 20;
  localparam int GAIN_W      = 16;
  localparam int ALPHA_W     = 13;
  localparam int DRIVE_W     = 16;
  localparam int CFG_LIMIT_W = 20;

  // signed multiplier operand A: holds 16-bit gains and the 13-bit alpha
  localparam int MUL_A_W = 18;

  localparam logic [GAIN_W-1:0]         PROP_GAIN_RST  = 16'd2540;
  localparam logic [GAIN_W-1:0]         INTEG_GAIN_RST = 16'd106;
  localparam logic [GAIN_W-1:0]         DERIV_GAIN_RST = 16'd0;
  localparam logic [ALPHA_W-1:0]        ALPHA_RST      = 13'd2867;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX_RST  = 16'sd80;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN_RST  = -16'sd80;
  localparam logic [CFG_LIMIT_W-1:0]    LIMIT_RST      = 20'd850;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN      = 3'd0,
    CFG_INTEG_GAIN     = 3'd1,
    CFG_DERIV_GAIN     = 3'd2,
    CFG_FILTER_ALPHA   = 3'd3,
    CFG_DRIVE_MAX      = 3'd4,
    CFG_DRIVE_MIN      = 3'd5,
    CFG_INTEGRAL_LIMIT = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0]         prop_gain;
    logic [GAIN_W-1:0]         integ_gain;
    logic [GAIN_W-1:0]         deriv_gain;
    logic [ALPHA_W-1:0]        filter_alpha;
    logic signed [DRIVE_W-1:0] drive_max;
    logic signed [DRIVE_W-1:0] drive_min;
    logic [CFG_LIMIT_W-1:0]    integral_limit;
  } cfg_t;

  typedef enum logic [1:0] {
    MAC_HOLD,
    MAC_LOAD,
    MAC_ADD
  } mac_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MIX_A,
    S_MIX_B,
    S_MIX_C,
    S_FILT,
    S_ERR,
    S_INTEG,
    S_CLAMP,
    S_PROD_I,
    S_PROD_D,
    S_SUM,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

// ===== design/fpsc_cfg.sv =====
// ----------------------------------------------------------------------------
// fpsc_cfg - configuration register file
// Write-only gain, filter and clamp registers, loaded by index.
// ----------------------------------------------------------------------------
`default_nettype none

module fpsc_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [fpsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [fpsc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output fpsc_pkg::cfg_t                        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain      <= fpsc_pkg::PROP_GAIN_RST;
      cfg.integ_gain     <= fpsc_pkg::INTEG_GAIN_RST;
      cfg.deriv_gain     <= fpsc_pkg::DERIV_GAIN_RST;
      cfg.filter_alpha   <= fpsc_pkg::ALPHA_RST;
      cfg.drive_max      <= fpsc_pkg::DRIVE_MAX_RST;
      cfg.drive_min      <= fpsc_pkg::DRIVE_MIN_RST;
      cfg.integral_limit <= fpsc_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      case (fpsc_pkg::cfg_idx_t'(cfg_index))
        fpsc_pkg::CFG_PROP_GAIN: begin
          cfg.prop_gain <= cfg_data[fpsc_pkg::GAIN_W-1:0];
        end
        fpsc_pkg::CFG_INTEG_GAIN: begin
          cfg.integ_gain <= cfg_data[fpsc_pkg::GAIN_W-1:0];
        end
        fpsc_pkg::CFG_DERIV_GAIN: begin
          cfg.deriv_gain <= cfg_data[fpsc_pkg::GAIN_W-1:0];
        end
        fpsc_pkg::CFG_FILTER_ALPHA: begin
          cfg.filter_alpha <= cfg_data[fpsc_pkg::ALPHA_W-1:0];
        end
        fpsc_pkg::CFG_DRIVE_MAX: begin
          cfg.drive_max <= $signed(cfg_data[fpsc_pkg::DRIVE_W-1:0]);
        end
        fpsc_pkg::CFG_DRIVE_MIN: begin
          cfg.drive_min <= $signed(cfg_data[fpsc_pkg::DRIVE_W-1:0]);
        end
        fpsc_pkg::CFG_INTEGRAL_LIMIT: begin
          cfg.integral_limit <= cfg_data[fpsc_pkg::CFG_LIMIT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/fpsc_mac.sv =====
// ----------------------------------------------------------------------------
// fpsc_mac - shared multiply-accumulate unit
// Registered signed product, then an accumulator that loads or adds it.
// ----------------------------------------------------------------------------
`default_nettype none

module fpsc_mac #(
  parameter int B_W   = 34,
  parameter int ACC_W = fpsc_pkg::MUL_A_W + B_W + 2
) (
  input  wire logic                                clk,
  input  wire logic signed [fpsc_pkg::MUL_A_W-1:0] mul_a,
  input  wire logic signed [B_W-1:0]               mul_b,
  input  wire fpsc_pkg::mac_op_t                   op,
  output logic signed [ACC_W-1:0]                  acc
);

  localparam int PROD_W = fpsc_pkg::MUL_A_W + B_W;

  logic signed [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (op)
      fpsc_pkg::MAC_LOAD: acc <= ACC_W'(prod);
      fpsc_pkg::MAC_ADD:  acc <= acc + ACC_W'(prod);
      default:            acc <= acc;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/filtered_pi_speed_controller.sv =====
// ----------------------------------------------------------------------------
// filtered_pi_speed_controller - filtered PI(D) wheel speed controller
// Encoder average, first-order low-pass, clamped integral and gain sum,
// all products taken on one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
//  channel  handshake             word
//  in       in_valid / in_ready   setpoint, left_count, right_count
//  out      out_valid / out_ready drive, drive_clamped
//  cfg      cfg_we                cfg_index, cfg_data
//
//  One word at a time: an 11-step sequencer around one multiplier and
//  accumulator, then back in idle to take the next word.
//  The result is written to the output register in the last step.
//  A result still waiting does not block acceptance; the sequencer only
//  stalls in its last step until the output register is free.
//  Synchronous reset clears filter, integral and previous error state.
// ----------------------------------------------------------------------------
`default_nettype none

module filtered_pi_speed_controller #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int FRAC_BITS    = 12
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0]         setpoint,
  input  wire logic signed [SAMPLE_WIDTH-1:0]         left_count,
  input  wire logic signed [SAMPLE_WIDTH-1:0]         right_count,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [fpsc_pkg::DRIVE_W-1:0]         drive,
  output logic                                        drive_clamped,
  input  wire logic                                   cfg_we,
  input  wire logic [fpsc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [fpsc_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int FW    = SAMPLE_WIDTH + FRAC_BITS;
  localparam int EW    = FW + 1;
  localparam int DW    = FW + 2;
  localparam int LIM_W = fpsc_pkg::CFG_LIMIT_W + FRAC_BITS;
  localparam int IW    = ((LIM_W > FW) ? LIM_W : FW) + 2;
  localparam int BW    = IW;
  localparam int AW    = fpsc_pkg::MUL_A_W + BW + 2;
  localparam int AL_W  = fpsc_pkg::MUL_A_W;

  localparam logic signed [AL_W-1:0] ONE_A = AL_W'(1) << FRAC_BITS;
  localparam logic signed [AW-1:0]   HALF  = AW'(1) << (FRAC_BITS - 1);

  fpsc_pkg::cfg_t    cfg;
  fpsc_pkg::state_t  state, state_next;
  fpsc_pkg::mac_op_t mac_op;

  logic signed [AL_W-1:0] mul_a;
  logic signed [BW-1:0]   mul_b;
  logic signed [AW-1:0]   acc;
  logic                   out_load;

  logic signed [SAMPLE_WIDTH-1:0] tgt;
  logic signed [FW-1:0]           avg;
  logic signed [FW-1:0]           fs;
  logic signed [EW-1:0]           err;
  logic signed [EW-1:0]           prev_err;
  logic signed [DW-1:0]           diff;
  logic signed [IW-1:0]           integ;

  logic signed [SAMPLE_WIDTH:0]   lr_sum;
  logic signed [AL_W-1:0]         alpha_in, alpha_eff, alpha_inv;
  logic signed [AW-1:0]           fs_round;
  logic signed [EW-1:0]           err_next;
  logic signed [IW-1:0]           lim_pos, lim_neg;
  logic signed [AW-1:0]           hi, lo, q_trunc;
  logic                           round_up;

  fpsc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fpsc_mac #(
    .B_W   (BW),
    .ACC_W (AW)
  ) u_mac (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .op    (mac_op),
    .acc   (acc)
  );

  assign lr_sum    = (SAMPLE_WIDTH+1)'(left_count) + (SAMPLE_WIDTH+1)'(right_count);
  assign alpha_in  = $signed(AL_W'(cfg.filter_alpha));
  assign alpha_eff = (alpha_in > ONE_A) ? ONE_A : alpha_in;
  assign alpha_inv = ONE_A - alpha_eff;
  assign fs_round  = acc + HALF;
  assign err_next  = EW'($signed({tgt, {FRAC_BITS{1'b0}}})) - EW'(fs);
  assign lim_pos   = IW'($signed({1'b0, cfg.integral_limit, {FRAC_BITS{1'b0}}}));
  assign lim_neg   = -lim_pos;
  assign hi        = AW'($signed({cfg.drive_max, {(2*FRAC_BITS){1'b0}}}));
  assign lo        = AW'($signed({cfg.drive_min, {(2*FRAC_BITS){1'b0}}}));
  assign round_up  = acc[AW-1] & (|acc[2*FRAC_BITS-1:0]);
  assign q_trunc   = (acc >>> (2*FRAC_BITS)) + $signed(AW'(round_up));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpsc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mac_op     = fpsc_pkg::MAC_HOLD;
    mul_a      = '0;
    mul_b      = '0;
    out_load   = 1'b0;
    case (state)
      fpsc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = fpsc_pkg::S_MIX_A;
        end
      end
      fpsc_pkg::S_MIX_A: begin
        mul_a      = alpha_eff;
        mul_b      = BW'(avg);
        state_next = fpsc_pkg::S_MIX_B;
      end
      fpsc_pkg::S_MIX_B: begin
        mul_a      = alpha_inv;
        mul_b      = BW'(fs);
        mac_op     = fpsc_pkg::MAC_LOAD;
        state_next = fpsc_pkg::S_MIX_C;
      end
      fpsc_pkg::S_MIX_C: begin
        mac_op     = fpsc_pkg::MAC_ADD;
        state_next = fpsc_pkg::S_FILT;
      end
      fpsc_pkg::S_FILT: begin
        state_next = fpsc_pkg::S_ERR;
      end
      fpsc_pkg::S_ERR: begin
        state_next = fpsc_pkg::S_INTEG;
      end
      fpsc_pkg::S_INTEG: begin
        state_next = fpsc_pkg::S_CLAMP;
      end
      fpsc_pkg::S_CLAMP: begin
        mul_a      = $signed(AL_W'(cfg.prop_gain));
        mul_b      = BW'(err);
        state_next = fpsc_pkg::S_PROD_I;
      end
      fpsc_pkg::S_PROD_I: begin
        mul_a      = $signed(AL_W'(cfg.integ_gain));
        mul_b      = integ;
        mac_op     = fpsc_pkg::MAC_LOAD;
        state_next = fpsc_pkg::S_PROD_D;
      end
      fpsc_pkg::S_PROD_D: begin
        mul_a      = $signed(AL_W'(cfg.deriv_gain));
        mul_b      = BW'(diff);
        mac_op     = fpsc_pkg::MAC_ADD;
        state_next = fpsc_pkg::S_SUM;
      end
      fpsc_pkg::S_SUM: begin
        mac_op     = fpsc_pkg::MAC_ADD;
        state_next = fpsc_pkg::S_OUT;
      end
      fpsc_pkg::S_OUT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = fpsc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fpsc_pkg::S_IDLE;
      end
    endcase
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      fs       <= '0;
      integ    <= '0;
      prev_err <= '0;
    end else begin
      case (state)
        fpsc_pkg::S_FILT: begin
          fs <= fs_round[FRAC_BITS +: FW];
        end
        fpsc_pkg::S_INTEG: begin
          integ    <= integ + IW'(err);
          prev_err <= err;
        end
        fpsc_pkg::S_CLAMP: begin
          if (integ > lim_pos) begin
            integ <= lim_pos;
          end else if (integ < lim_neg) begin
            integ <= lim_neg;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // per-word working registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tgt <= setpoint;
      avg <= $signed({lr_sum, {(FRAC_BITS-1){1'b0}}});
    end
    if (state == fpsc_pkg::S_ERR) begin
      err <= err_next;
    end
    if (state == fpsc_pkg::S_INTEG) begin
      diff <= DW'(err) - DW'(prev_err);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (acc > hi) begin
        drive         <= cfg.drive_max;
        drive_clamped <= 1'b1;
      end else if (acc < lo) begin
        drive         <= cfg.drive_min;
        drive_clamped <= 1'b1;
      end else begin
        drive         <= q_trunc[fpsc_pkg::DRIVE_W-1:0];
        drive_clamped <= 1'b0;
      end
    end
  end

  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready
  ) else $error("input accepted while sequencer busy");

  a_out_stall_holds: assert property (
    @(posedge clk) disable iff (rst)
    (state == fpsc_pkg::S_OUT && out_valid && !out_ready) |=> (state == fpsc_pkg::S_OUT)
  ) else $error("result overwrote a word still waiting");

  a_integral_bounded: assert property (
    @(posedge clk) disable iff (rst)
    (state == fpsc_pkg::S_PROD_I && $stable(cfg.integral_limit))
      |-> (integ <= lim_pos) && (integ >= lim_neg)
  ) else $error("integral outside its clamp");

endmodule

`default_nettype wire

// ===== sim/filtered_pi_speed_controller_checker.sv =====
// ----------------------------------------------------------------------------
// filtered_pi_speed_controller_checker - drive word predictor and scoreboard
// Follows the register port and the input channel and computes the drive
// expected for every accepted word. Each accepted output word is compared
// with the oldest prediction. Failures and words still owed go to the top.
// ----------------------------------------------------------------------------
module filtered_pi_speed_controller_checker #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int FRAC_BITS    = 12
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    in_valid,
  input  wire logic                                    in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0]          setpoint,
  input  wire logic signed [SAMPLE_WIDTH-1:0]          left_count,
  input  wire logic signed [SAMPLE_WIDTH-1:0]          right_count,
  input  wire logic                                    out_valid,
  input  wire logic                                    out_ready,
  input  wire logic signed [fpsc_pkg::DRIVE_W-1:0]     drive,
  input  wire logic                                    drive_clamped,
  input  wire logic                                    cfg_we,
  input  wire logic [fpsc_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [fpsc_pkg::CFG_DATA_W-1:0]         cfg_data,
  output int                                           fail_count,
  output int                                           pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [fpsc_pkg::DRIVE_W-1:0] drive;
    logic                                clamped;
  } drive_word_t;

  drive_word_t    drive_fifo[$];
  drive_word_t    want;
  fpsc_pkg::cfg_t regs;
  longint         filt_speed;
  longint         integ_acc;
  longint         last_err;

  function automatic drive_word_t predict_drive(input longint tgt, input longint lc,
                                                input longint rc);
    longint      one;
    longint      alpha;
    longint      avg;
    longint      mix;
    longint      err;
    longint      lim;
    longint      sum;
    longint      hi;
    longint      lo;
    longint      mag;
    drive_word_t w;
    one   = longint'(1) <<< FRAC_BITS;
    alpha = longint'(regs.filter_alpha);
    if (alpha > one) alpha = one;
    avg        = (lc + rc) * (longint'(1) <<< (FRAC_BITS - 1));
    mix        = alpha * avg + (one - alpha) * filt_speed;
    filt_speed = (mix + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    err        = tgt * one - filt_speed;
    lim        = longint'(regs.integral_limit) * one;
    integ_acc  = integ_acc + err;
    if (integ_acc > lim) begin
      integ_acc = lim;
    end else if (integ_acc < -lim) begin
      integ_acc = -lim;
    end
    sum = longint'(regs.prop_gain) * err + longint'(regs.integ_gain) * integ_acc
        + longint'(regs.deriv_gain) * (err - last_err);
    hi  = longint'(regs.drive_max) * (longint'(1) <<< (2 * FRAC_BITS));
    lo  = longint'(regs.drive_min) * (longint'(1) <<< (2 * FRAC_BITS));
    if (sum > hi) begin
      w.drive   = regs.drive_max;
      w.clamped = 1'b1;
    end else if (sum < lo) begin
      w.drive   = regs.drive_min;
      w.clamped = 1'b1;
    end else begin
      // truncate toward zero
      mag       = (sum < 0) ? -sum : sum;
      mag       = mag >>> (2 * FRAC_BITS);
      w.drive   = fpsc_pkg::DRIVE_W'((sum < 0) ? -mag : mag);
      w.clamped = 1'b0;
    end
    last_err = err;
    return w;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      regs.prop_gain      = fpsc_pkg::PROP_GAIN_RST;
      regs.integ_gain     = fpsc_pkg::INTEG_GAIN_RST;
      regs.deriv_gain     = fpsc_pkg::DERIV_GAIN_RST;
      regs.filter_alpha   = fpsc_pkg::ALPHA_RST;
      regs.drive_max      = fpsc_pkg::DRIVE_MAX_RST;
      regs.drive_min      = fpsc_pkg::DRIVE_MIN_RST;
      regs.integral_limit = fpsc_pkg::LIMIT_RST;
      filt_speed          = 0;
      integ_acc           = 0;
      last_err            = 0;
      drive_fifo.delete();
      fail_count          = 0;
      pending_count       = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (drive_fifo.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected drive word %0d/%0b", drive, drive_clamped);
        end else begin
          want = drive_fifo.pop_front();
          if (drive !== want.drive || drive_clamped !== want.clamped) begin
            fail_count++;
            if (fail_count <= 10)
              $display("drive mismatch: expected %0d/%0b, got %0d/%0b",
                       want.drive, want.clamped, drive, drive_clamped);
          end
        end
      end
      if (cfg_we) begin
        case (fpsc_pkg::cfg_idx_t'(cfg_index))
          fpsc_pkg::CFG_PROP_GAIN:
            regs.prop_gain = cfg_data[fpsc_pkg::GAIN_W-1:0];
          fpsc_pkg::CFG_INTEG_GAIN:
            regs.integ_gain = cfg_data[fpsc_pkg::GAIN_W-1:0];
          fpsc_pkg::CFG_DERIV_GAIN:
            regs.deriv_gain = cfg_data[fpsc_pkg::GAIN_W-1:0];
          fpsc_pkg::CFG_FILTER_ALPHA:
            regs.filter_alpha = cfg_data[fpsc_pkg::ALPHA_W-1:0];
          fpsc_pkg::CFG_DRIVE_MAX:
            regs.drive_max = cfg_data[fpsc_pkg::DRIVE_W-1:0];
          fpsc_pkg::CFG_DRIVE_MIN:
            regs.drive_min = cfg_data[fpsc_pkg::DRIVE_W-1:0];
          fpsc_pkg::CFG_INTEGRAL_LIMIT:
            regs.integral_limit = cfg_data[fpsc_pkg::CFG_LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        drive_fifo.push_back(predict_drive(setpoint, left_count, right_count));
      pending_count = drive_fifo.size();
    end
  end

endmodule

// ===== sim/filtered_pi_speed_controller_tb.sv =====
// ----------------------------------------------------------------------------
// filtered_pi_speed_controller_tb - speed controller testbench
// Directed words for the filter tie, the clamp boundaries, truncation toward
// zero and an inverted clamp window, then random phases over typical, extreme
// and random gain settings, with random idling on both channels but in the last three.
// ----------------------------------------------------------------------------
module filtered_pi_speed_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic                              clk;
  logic                              rst;
  logic                              in_valid;
  wire logic                         in_ready;
  logic signed [15:0]                setpoint;
  logic signed [15:0]                left_count;
  logic signed [15:0]                right_count;
  wire logic                         out_valid;
  logic                              out_ready;
  wire logic signed [15:0]           drive;
  wire logic                         drive_clamped;
  logic                              cfg_we;
  logic [fpsc_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [fpsc_pkg::CFG_DATA_W-1:0]   cfg_data;
  int                                fail_count;
  int                                pending_count;

  int                                send_idle_pct;
  int                                recv_idle_pct;
  int                                cycles;
  int                                base;
  logic signed [15:0]                t_s;
  logic signed [15:0]                l_s;
  logic signed [15:0]                r_s;

  filtered_pi_speed_controller u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .setpoint      (setpoint),
    .left_count    (left_count),
    .right_count   (right_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .drive         (drive),
    .drive_clamped (drive_clamped),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  filtered_pi_speed_controller_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .setpoint      (setpoint),
    .left_count    (left_count),
    .right_count   (right_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .drive         (drive),
    .drive_clamped (drive_clamped),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("filtered_pi_speed_controller_tb NOT OK");
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // entered and left at a falling edge
  task automatic send_word(input logic signed [15:0] tgt, input logic signed [15:0] lc,
                           input logic signed [15:0] rc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    setpoint    <= tgt;
    left_count  <= lc;
    right_count <= rc;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input fpsc_pkg::cfg_idx_t idx,
                           input logic [fpsc_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  task automatic load_config(input logic [15:0] kp, input logic [15:0] ki,
                             input logic [15:0] kd, input logic [12:0] alpha,
                             input logic signed [15:0] hi, input logic signed [15:0] lo,
                             input logic [19:0] lim);
    write_reg(fpsc_pkg::CFG_PROP_GAIN, fpsc_pkg::CFG_DATA_W'(kp));
    write_reg(fpsc_pkg::CFG_INTEG_GAIN, fpsc_pkg::CFG_DATA_W'(ki));
    write_reg(fpsc_pkg::CFG_DERIV_GAIN, fpsc_pkg::CFG_DATA_W'(kd));
    write_reg(fpsc_pkg::CFG_FILTER_ALPHA, fpsc_pkg::CFG_DATA_W'(alpha));
    write_reg(fpsc_pkg::CFG_DRIVE_MAX, fpsc_pkg::CFG_DATA_W'(hi));
    write_reg(fpsc_pkg::CFG_DRIVE_MIN, fpsc_pkg::CFG_DATA_W'(lo));
    write_reg(fpsc_pkg::CFG_INTEGRAL_LIMIT, fpsc_pkg::CFG_DATA_W'(lim));
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    wait (pending_count == 0);
    @(negedge clk);
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    setpoint      = '0;
    left_count    = '0;
    right_count   = '0;
    cfg_we        = 1'b0;
    cfg_index     = fpsc_pkg::CFG_PROP_GAIN;
    cfg_data      = '0;
    send_idle_pct = 28;
    recv_idle_pct = 70;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings; first word lands on a filter tie
    send_word(16'sd0, 16'sd1, 16'sd0);
    send_word(16'sd0, 16'sd0, 16'sd0);
    send_word(16'sd32767, 16'sd32767, 16'sd32767);
    send_word(-16'sd32768, -16'sd32768, -16'sd32768);
    send_word(16'sd32767, -16'sd32768, -16'sd32768);
    send_word(-16'sd32768, 16'sd32767, 16'sd32767);
    send_word(16'sd100, 16'sd1, 16'sd0);
    send_word(-16'sd100, -16'sd1, 16'sd0);
    wait_drained();

    // unity gain, no filtering: clamp boundaries and truncation
    load_config(16'd4096, 16'd0, 16'd0, 13'd4096, 16'sd80, -16'sd80, 20'd850);
    send_word(16'sd80, 16'sd0, 16'sd0);
    send_word(16'sd81, 16'sd0, 16'sd0);
    send_word(-16'sd80, 16'sd0, 16'sd0);
    send_word(-16'sd81, 16'sd0, 16'sd0);
    send_word(16'sd0, 16'sd1, 16'sd0);
    send_word(16'sd0, -16'sd1, 16'sd0);
    send_word(16'sd0, -16'sd3, 16'sd0);
    wait_drained();

    // alpha above one, zero integral limit, inverted clamp window
    load_config(16'd0, 16'd65535, 16'd65535, 13'd8191, -16'sd10, 16'sd10, 20'd0);
    send_word(16'sd5, 16'sd3, 16'sd2);
    send_word(-16'sd5, 16'sd0, 16'sd0);
    send_word(16'sd0, 16'sd0, 16'sd0);
    send_word(16'sd1000, -16'sd7, 16'sd9);

    for (int p = 0; p < 9; p++) begin
      wait_drained();
      send_idle_pct = (p < 3) ? 28 : (p < 6) ? 70 : 0;
      recv_idle_pct = (p < 3) ? 70 : (p < 6) ? 28 : 0;
      case (p)
        1: load_config(16'd65535, 16'd65535, 16'd65535, 13'd4096, 16'sd32767,
                       -16'sd32768, 20'd1048575);
        4: load_config(16'd65535, 16'd0, 16'd0, 13'd1, 16'sd0, 16'sd0, 20'd0);
        7: load_config(16'($urandom_range(8192)), 16'($urandom_range(512)),
                       16'($urandom_range(2048)), 13'd2048,
                       16'($urandom_range(32767)), 16'(-$urandom_range(32768)),
                       20'($urandom_range(4000)));
        2, 5, 8: load_config(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                             16'($urandom_range(65535)), 13'($urandom_range(8191)),
                             16'($urandom_range(65535)), 16'($urandom_range(65535)),
                             20'($urandom_range(1048575)));
        default: load_config(16'($urandom_range(8192)), 16'($urandom_range(512)),
                             16'($urandom_range(2048)), 13'($urandom_range(4096)),
                             16'($urandom_range(32767)), 16'(-$urandom_range(32768)),
                             20'($urandom_range(4000)));
      endcase
      repeat (95) begin
        if ($urandom_range(99) < 70) begin
          // wheels near the target
          base = int'($urandom_range(600)) - 300;
          t_s  = 16'(base);
          l_s  = 16'(base + int'($urandom_range(40)) - 20);
          r_s  = 16'(base + int'($urandom_range(40)) - 20);
        end else begin
          t_s = 16'($urandom_range(65535));
          l_s = 16'($urandom_range(65535));
          r_s = 16'($urandom_range(65535));
        end
        send_word(t_s, l_s, r_s);
      end
    end

    wait_drained();
    repeat (30) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("filtered_pi_speed_controller_tb OK");
    else
      $display("filtered_pi_speed_controller_tb NOT OK");
    $finish;
  end

endmodule
